// ----- hw/rtl/ctr_pkg.sv -----
package ctr_pkg;

    // field and datapath widths
    localparam int unsigned MANT_W  = 23;
    localparam int unsigned EXP_W   = 9;    // room for one step past 255
    localparam int unsigned NUM_W   = 76;   // scaled mantissa numerator
    localparam int unsigned DEN_W   = 52;   // ideal window, up to one base-256 step
    localparam int unsigned QUO_W   = 24;   // coefficient search width
    localparam int unsigned IDEAL_W = 42;   // seconds * 1000 * interval
    localparam int unsigned MS_W    = 26;   // seconds * 1000
    localparam int unsigned RATIO_W = 43;   // clamped span numerator

    localparam logic [MANT_W-1:0] MANT_MAX    = 23'h7fffff;
    localparam logic [7:0]        EASIEST_EXP = 8'd32;
    localparam logic [EXP_W-1:0]  MIN_SHIFT_EXP = 9'd3;
    localparam logic [9:0]        MS_PER_SEC  = 10'd1000;
    localparam int unsigned       NORM_LOW_SH = 15;    // 32768 = 1 << 15

    // configuration register indexes
    localparam logic [1:0] CFG_INTERVAL    = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SECS  = 2'd1;
    localparam logic [1:0] CFG_INIT_TARGET = 2'd2;

    localparam logic [15:0] RST_INTERVAL    = 16'd2016;
    localparam logic [15:0] RST_BLOCK_SECS  = 16'd60;
    localparam logic [31:0] RST_INIT_TARGET = 32'h1d00ffff;

    // outcome codes
    localparam logic [2:0] OUTC_YOUNG     = 3'd0;
    localparam logic [2:0] OUTC_KEPT      = 3'd1;
    localparam logic [2:0] OUTC_MALFORMED = 3'd2;
    localparam logic [2:0] OUTC_SATURATED = 3'd3;
    localparam logic [2:0] OUTC_COMPUTED  = 3'd4;

    typedef struct packed {
        logic [31:0] chain_length;
        logic [63:0] window_start_time;
        logic [63:0] window_end_time;
        logic [31:0] current_target;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] next_target;
        logic [2:0]  outcome;
    } t_out_beat;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_res;

endpackage

// ----- hw/rtl/compact_target_retarget_core.sv -----
// channel   dir   handshake                   payload
// in        in    i_in_valid / o_in_ready     i_in_beat  (t_in_beat)
// out       out   o_out_valid / i_out_ready   o_out_beat (t_out_beat)
// cfg       in    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// a computed beat is dominated by the 24 steps of the restoring divider, plus
// the base-256 normalization steps; young, kept and malformed beats go from
// the check state straight to done.
// one beat is in flight at a time: o_in_ready is high only in idle.
// a finished result waits in the output register, so the next beat may be
// taken while it stalls; reset is synchronous, active low, config always ready.
module compact_target_retarget_core
    import ctr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_beat,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHK   = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_MUL2  = 10'b0000001000,
        S_CLAMP = 10'b0000010000,
        S_MULN  = 10'b0000100000,
        S_NORM1 = 10'b0001000000,
        S_NORM2 = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_cfg_interval;
    logic [15:0] r_cfg_secs;
    logic [31:0] r_cfg_init;

    // datapath registers
    t_in_beat            r_in;
    logic [63:0]         r_span, n_span;
    logic [IDEAL_W-1:0]  r_prod, n_prod;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [EXP_W-1:0]    r_exp, n_exp;
    t_out_beat           r_res, n_res;
    t_out_beat           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // input field views
    logic [7:0]          w_cur_exp;
    logic [MANT_W-1:0]   w_cur_mant;
    logic                w_young;
    logic                w_span_pos;
    logic [63:0]         w_span;

    // shared products and compares
    logic [MS_W-1:0]     w_ms;
    logic [IDEAL_W-1:0]  w_ideal;
    logic [63:0]         w_ideal2;
    logic [RATIO_W:0]    w_span2;
    logic [65:0]         w_scaled;
    logic [NUM_W-1:0]    w_hi_bound;
    logic [NUM_W-1:0]    w_lo_bound;
    logic                w_over;
    logic                w_under;
    logic [7:0]          w_exp_out;
    logic [QUO_W-1:0]    w_coeff;

    t_div_req w_div_req;
    t_div_res w_div_res;

    logic w_in_acc;
    logic w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_out_free = ~r_out_valid | i_out_ready;

    assign w_cur_exp  = r_in.current_target[31:24];
    assign w_cur_mant = r_in.current_target[MANT_W-1:0];
    assign w_young    = (r_in.chain_length < {16'd0, r_cfg_interval});
    assign w_span_pos = (r_in.window_end_time > r_in.window_start_time);
    assign w_span     = r_in.window_end_time - r_in.window_start_time;

    // ideal window built in two small multiplies
    assign w_ms     = r_cfg_secs * MS_PER_SEC;
    assign w_ideal  = r_prod[MS_W-1:0] * r_cfg_interval;
    assign w_ideal2 = 64'({r_prod, 1'b0});
    // only looked at once span < 2 * ideal, so the low bits hold all of span
    assign w_span2  = {r_span[RATIO_W-1:0], 1'b0};
    assign w_scaled = w_cur_mant * r_num[RATIO_W-1:0];

    // den * 0x7fffff and den * 32768 as shift and subtract
    assign w_hi_bound = NUM_W'({r_den, {MANT_W{1'b0}}}) - NUM_W'(r_den);
    assign w_lo_bound = NUM_W'({r_den, {NORM_LOW_SH{1'b0}}});
    assign w_over     = (r_num > w_hi_bound);
    assign w_under    = (r_num != '0) && (r_num < w_lo_bound) && (r_exp > MIN_SHIFT_EXP);

    assign w_exp_out = (r_exp == '0) ? 8'd1 : r_exp[7:0];

    // coefficient forced into [1, 0x7fffff]
    always_comb begin
        w_coeff = w_div_res.quo;
        if (w_coeff == '0) begin
            w_coeff = QUO_W'(1);
        end
        if (w_coeff > QUO_W'(MANT_MAX)) begin
            w_coeff = QUO_W'(MANT_MAX);
        end
    end

    assign w_div_req.start = (r_state == S_NORM2) && !w_under && !(r_exp > EXP_W'(EASIEST_EXP));
    assign w_div_req.num   = r_num;
    assign w_div_req.den   = r_den;

    ctr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_res   (w_div_res)
    );

    always_comb begin
        n_state     = r_state;
        n_span      = r_span;
        n_prod      = r_prod;
        n_num       = r_num;
        n_den       = r_den;
        n_exp       = r_exp;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_exp  = EXP_W'(w_cur_exp);
                n_span = w_span;
                if (w_young) begin
                    n_res   = '{next_target: r_cfg_init, outcome: OUTC_YOUNG};
                    n_state = S_DONE;
                end else if (!w_span_pos) begin
                    n_res   = '{next_target: r_in.current_target, outcome: OUTC_KEPT};
                    n_state = S_DONE;
                end else if (w_cur_exp == '0 || w_cur_mant == '0) begin
                    n_res   = '{next_target: r_cfg_init, outcome: OUTC_MALFORMED};
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = IDEAL_W'(w_ms);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_prod  = w_ideal;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                // ratio clamped to [1/2, 2]; zero ideal lands on the upper clamp
                if (r_span >= w_ideal2) begin
                    n_num = NUM_W'(2);
                    n_den = DEN_W'(1);
                end else if (w_span2 <= (RATIO_W+1)'(r_prod)) begin
                    n_num = NUM_W'(1);
                    n_den = DEN_W'(2);
                end else begin
                    n_num = NUM_W'(r_span[RATIO_W-1:0]);
                    n_den = DEN_W'(r_prod);
                end
                n_state = S_MULN;
            end
            S_MULN: begin
                n_num   = NUM_W'(w_scaled);
                n_state = S_NORM1;
            end
            S_NORM1: begin
                if (w_over) begin
                    n_den = r_den << 8;
                    n_exp = r_exp + 1'b1;
                end else begin
                    n_state = S_NORM2;
                end
            end
            S_NORM2: begin
                if (w_under) begin
                    n_num = r_num << 8;
                    n_exp = r_exp - 1'b1;
                end else if (r_exp > EXP_W'(EASIEST_EXP)) begin
                    n_res   = '{next_target: {EASIEST_EXP, 1'b0, MANT_MAX},
                                outcome: OUTC_SATURATED};
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_res.done) begin
                    n_res   = '{next_target: {w_exp_out, 1'b0, w_coeff[MANT_W-1:0]},
                                outcome: OUTC_COMPUTED};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (w_in_acc) begin
            r_in <= i_in_beat;
        end
        r_span <= n_span;
        r_prod <= n_prod;
        r_num  <= n_num;
        r_den  <= n_den;
        r_exp  <= n_exp;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // config writes, unknown index dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_interval <= RST_INTERVAL;
            r_cfg_secs     <= RST_BLOCK_SECS;
            r_cfg_init     <= RST_INIT_TARGET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INTERVAL:    r_cfg_interval <= i_cfg_data[15:0];
                CFG_BLOCK_SECS:  r_cfg_secs     <= i_cfg_data[15:0];
                CFG_INIT_TARGET: r_cfg_init     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/ctr_div.sv -----
module ctr_div
    import ctr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    localparam int unsigned DSH_W = DEN_W + QUO_W - 1;
    localparam int unsigned CNT_W = $clog2(QUO_W);

    logic [NUM_W-1:0] r_rem, n_rem;
    logic [DSH_W-1:0] r_dsh, n_dsh;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [NUM_W-1:0] w_dsh_ext;
    logic             w_fit;

    // one restoring step per cycle, quotient bits msb first
    assign w_dsh_ext = NUM_W'(r_dsh);
    assign w_fit     = (w_dsh_ext <= r_rem);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, {(QUO_W-1){1'b0}}};
            n_quo  = '0;
            n_cnt  = CNT_W'(QUO_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_fit) begin
                n_rem = r_rem - w_dsh_ext;
            end
            n_quo = {r_quo[QUO_W-2:0], w_fit};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;

endmodule
